@@ rtl/ssdc_pkg.sv @@
// Shared types, command codes, indicator masks, glyph table and divider constants.
package ssdc_pkg;

    typedef logic [4:0] code_t;
    typedef logic [2:0] pos_t;
    typedef logic [7:0] seg_t;

    typedef enum logic [3:0] {
        KIND_TICK       = 4'd0,
        KIND_SHOW_TIME  = 4'd1,
        KIND_SET_TIME   = 4'd2,
        KIND_SET_PULSE  = 4'd3,
        KIND_SHOW_VALUE = 4'd4,
        KIND_MONEY      = 4'd5,
        KIND_PAY_MONEY  = 4'd6,
        KIND_SET_MONEY  = 4'd7,
        KIND_RUNNING    = 4'd8,
        KIND_ERROR      = 4'd9,
        KIND_ALL_ON     = 4'd10,
        KIND_ALL_OFF    = 4'd11
    } kind_t;

    localparam seg_t IND_SET   = 8'h80;
    localparam seg_t IND_POINT = 8'h40;
    localparam seg_t IND_MONEY = 8'h20;
    localparam seg_t IND_TIME  = 8'h10;
    localparam seg_t IND_ERROR = 8'h08;
    localparam seg_t IND_PULSE = 8'h04;
    localparam seg_t IND_UNIT  = 8'h01;
    localparam seg_t IND_MODE  = IND_SET | IND_TIME | IND_MONEY | IND_POINT | IND_UNIT;

    localparam seg_t SEG_MASK        = 8'hFD;
    localparam int   SEG_UNUSED_BIT  = 1;

    localparam code_t CODE_DASH  = 5'd16;
    localparam code_t CODE_BLANK = 5'd19;
    localparam code_t CODE_SAT   = 5'd31;

    localparam pos_t POS_LAMPS = 3'd4;

    localparam code_t DIGIT_RESET [4] = '{5'd1, 5'd7, 5'd0, 5'd1};

    // Reciprocal multipliers, exact for every 16-bit dividend.
    localparam logic [32:0] DIV10_MUL    = 33'd52429;
    localparam int          DIV10_SHIFT  = 19;
    localparam logic [32:0] DIV100_MUL   = 33'd83887;
    localparam int          DIV100_SHIFT = 23;
    localparam logic [32:0] DIV1K_MUL    = 33'd67109;
    localparam int          DIV1K_SHIFT  = 26;
    localparam logic [32:0] DIV10K_MUL   = 33'd107375;
    localparam int          DIV10K_SHIFT = 30;
    localparam logic [32:0] DIV60_MUL    = 33'd34953;
    localparam int          DIV60_SHIFT  = 21;
    localparam logic [32:0] DIV3600_MUL  = 33'd37283;
    localparam int          DIV3600_SHIFT = 27;

    function automatic seg_t glyph(input code_t code);
        seg_t pat;
        begin
            case (code)
                5'd0:    pat = 8'hFC;
                5'd1:    pat = 8'h18;
                5'd2:    pat = 8'h6D;
                5'd3:    pat = 8'h3D;
                5'd4:    pat = 8'h99;
                5'd5:    pat = 8'hB5;
                5'd6:    pat = 8'hF5;
                5'd7:    pat = 8'h1C;
                5'd8:    pat = 8'hFD;
                5'd9:    pat = 8'hBD;
                5'd10:   pat = 8'hDD;
                5'd11:   pat = 8'hF1;
                5'd12:   pat = 8'hE4;
                5'd13:   pat = 8'h79;
                5'd14:   pat = 8'hE5;
                5'd15:   pat = 8'hC5;
                5'd16:   pat = 8'h01;
                5'd17:   pat = 8'hCD;
                5'd18:   pat = 8'hF8;
                5'd19:   pat = 8'h00;
                5'd20:   pat = 8'hFD;
                default: pat = 8'h00;
            endcase
            return pat;
        end
    endfunction

endpackage

@@ rtl/seven_segment_display_controller_unit.sv @@
// Top level of the multiplexed seven-segment display controller.
//
// The block takes one command or tick transaction per clock cycle. Each accepted
// transaction is held in an input register and then handled by one decode and
// decimal-formatting stage that updates the digit codes, indicator lamps,
// override latch and dash animation; a tick instead advances the scan position
// and loads the output register, from which its segment transaction is offered.
// Commands produce no output transaction. The input stalls only when a tick
// waits in the input register while the output register still holds an
// untaken transaction. Decimal conversion uses constant reciprocal multipliers
// in that single stage, which sets the one-transaction-per-cycle rate.
module seven_segment_display_controller_unit
    import ssdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [3:0]  kind,
    input  logic [15:0] value,
    input  logic        flag,
    output logic        seg_valid,
    input  logic        seg_stall,
    output logic [2:0]  position,
    output logic [7:0]  segments
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [3:0]  s1_kind_reg;
    logic [15:0] s1_value_reg;
    logic        s1_flag_reg;

    code_t       digit_reg [4];
    code_t       digit_next [4];
    seg_t        ind_reg;
    seg_t        ind_next;
    pos_t        scan_pos_reg;
    pos_t        scan_pos_next;
    logic        latch_reg;
    logic        latch_next;
    logic [2:0]  anim_reg;
    logic [2:0]  anim_next;

    logic        seg_valid_reg;
    logic        seg_valid_next;
    pos_t        position_reg;
    pos_t        position_next;
    seg_t        segments_reg;
    seg_t        segments_next;

    logic        s1_is_tick;
    logic        out_room;
    logic        s1_go;
    logic        cmd_accept;

    logic [32:0] p10;
    logic [32:0] p100;
    logic [32:0] p1k;
    logic [32:0] p10k;
    logic [32:0] p60;
    logic [32:0] p3600;
    logic [12:0] q10;
    logic [9:0]  q100;
    logic [6:0]  q1k;
    logic [2:0]  q10k;
    logic [10:0] q60;
    logic [4:0]  q3600;

    logic [9:0]  r1_full;
    logic [12:0] r2_full;
    logic [15:0] r3_full;
    logic [6:0]  rm_full;
    logic [3:0]  dig_h;
    logic [3:0]  dig_t;
    logic [3:0]  dig_u;
    logic [3:0]  dig_m;
    code_t       num_th;

    logic [10:0] hr_full;
    logic [15:0] mn_full;
    logic [5:0]  hr;
    logic [5:0]  mn;
    logic [9:0]  hr_prod;
    logic [9:0]  mn_prod;
    logic [2:0]  hr_tens;
    logic [2:0]  mn_tens;
    logic [5:0]  hr_unit_full;
    logic [5:0]  mn_unit_full;

    code_t       num_codes [4];
    code_t       money_codes [4];
    code_t       time_codes [4];
    logic        time_zero;
    logic        time_point;
    seg_t        time_ind;
    seg_t        money_ind;
    pos_t        scan_step;
    seg_t        tick_pat;

    assign s1_is_tick = (s1_kind_reg == KIND_TICK);
    assign out_room   = !seg_valid_reg || !seg_stall;
    assign s1_go      = s1_valid_reg && (!s1_is_tick || out_room);
    assign cmd_stall  = s1_valid_reg && !s1_go;
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign seg_valid = seg_valid_reg;
    assign position  = position_reg;
    assign segments  = segments_reg;

    assign p10   = 33'(s1_value_reg) * DIV10_MUL;
    assign p100  = 33'(s1_value_reg) * DIV100_MUL;
    assign p1k   = 33'(s1_value_reg) * DIV1K_MUL;
    assign p10k  = 33'(s1_value_reg) * DIV10K_MUL;
    assign p60   = 33'(s1_value_reg) * DIV60_MUL;
    assign p3600 = 33'(s1_value_reg) * DIV3600_MUL;

    assign q10   = p10[DIV10_SHIFT +: 13];
    assign q100  = p100[DIV100_SHIFT +: 10];
    assign q1k   = p1k[DIV1K_SHIFT +: 7];
    assign q10k  = p10k[DIV10K_SHIFT +: 3];
    assign q60   = p60[DIV60_SHIFT +: 11];
    assign q3600 = p3600[DIV3600_SHIFT +: 5];

    assign r1_full = q100 - 10'(q1k) * 10'd10;
    assign r2_full = q10 - 13'(q100) * 13'd10;
    assign r3_full = s1_value_reg - 16'(q10) * 16'd10;
    assign rm_full = q1k - 7'(q10k) * 7'd10;
    assign dig_h   = r1_full[3:0];
    assign dig_t   = r2_full[3:0];
    assign dig_u   = r3_full[3:0];
    assign dig_m   = rm_full[3:0];
    assign num_th  = (q1k > 7'(CODE_SAT)) ? CODE_SAT : q1k[4:0];

    assign hr_full      = q60 - 11'(q3600) * 11'd60;
    assign mn_full      = s1_value_reg - 16'(q60) * 16'd60;
    assign hr           = hr_full[5:0];
    assign mn           = mn_full[5:0];
    assign hr_prod      = 10'(hr) * 10'd13;
    assign mn_prod      = 10'(mn) * 10'd13;
    assign hr_tens      = hr_prod[9:7];
    assign mn_tens      = mn_prod[9:7];
    assign hr_unit_full = hr - 6'(hr_tens) * 6'd10;
    assign mn_unit_full = mn - 6'(mn_tens) * 6'd10;

    assign time_zero  = (s1_value_reg == 16'd0);
    assign time_point = (s1_kind_reg == KIND_SET_TIME) ? 1'b1 : s1_flag_reg;
    assign time_ind   = time_zero ? 8'h00
                      : ((ind_reg & ~IND_MODE) | IND_TIME | (time_point ? IND_POINT : 8'h00));
    assign money_ind  = (ind_reg & ~IND_MODE) | IND_MONEY;

    assign scan_step = (scan_pos_reg == POS_LAMPS) ? 3'd0 : scan_pos_reg + 3'd1;
    assign tick_pat  = ((scan_step == POS_LAMPS) ? ind_reg : glyph(digit_reg[scan_step[1:0]]))
                     & SEG_MASK;

    always_comb
    begin
        num_codes[0]   = num_th;
        num_codes[1]   = {1'b0, dig_h};
        num_codes[2]   = {1'b0, dig_t};
        num_codes[3]   = {1'b0, dig_u};
        money_codes[0] = {2'b00, q10k};
        money_codes[1] = {1'b0, dig_m};
        money_codes[2] = {1'b0, dig_h};
        money_codes[3] = {1'b0, dig_t};
        for (int i = 0; i < 4; i++)
        begin
            time_codes[i] = (2'(i) == anim_reg[2:1]) ? CODE_DASH : CODE_BLANK;
        end
        if (!time_zero)
        begin
            time_codes[0] = {2'b00, hr_tens};
            time_codes[1] = {1'b0, hr_unit_full[3:0]};
            time_codes[2] = {2'b00, mn_tens};
            time_codes[3] = {1'b0, mn_unit_full[3:0]};
        end
    end

    always_comb
    begin
        digit_next    = digit_reg;
        ind_next      = ind_reg;
        latch_next    = latch_reg;
        anim_next     = anim_reg;
        scan_pos_next = scan_pos_reg;
        position_next = position_reg;
        segments_next = segments_reg;
        if (s1_go)
        begin
            case (s1_kind_reg)
                KIND_TICK:
                begin
                    scan_pos_next = scan_step;
                    position_next = scan_step;
                    segments_next = tick_pat;
                end
                KIND_SHOW_TIME, KIND_SET_TIME:
                begin
                    digit_next = time_codes;
                    ind_next   = time_ind;
                    if (s1_kind_reg == KIND_SET_TIME)
                    begin
                        ind_next = time_ind | IND_SET;
                    end
                    if (time_zero)
                    begin
                        anim_next = anim_reg + 3'd1;
                    end
                end
                KIND_SET_PULSE:
                begin
                    digit_next = num_codes;
                    ind_next   = (ind_reg & ~IND_MODE) | IND_SET | IND_PULSE;
                end
                KIND_SHOW_VALUE:
                begin
                    digit_next = num_codes;
                end
                KIND_MONEY:
                begin
                    digit_next = money_codes;
                    ind_next   = money_ind | IND_UNIT;
                end
                KIND_PAY_MONEY:
                begin
                    digit_next = money_codes;
                    ind_next   = money_ind;
                end
                KIND_SET_MONEY:
                begin
                    digit_next = money_codes;
                    ind_next   = money_ind | IND_UNIT | IND_SET;
                end
                KIND_RUNNING:
                begin
                    if (((ind_reg & IND_SET) == 8'h00) && !latch_reg)
                    begin
                        ind_next = s1_flag_reg ? (ind_reg | IND_PULSE) : (ind_reg & ~IND_PULSE);
                    end
                end
                KIND_ERROR:
                begin
                    if (!latch_reg)
                    begin
                        ind_next = s1_flag_reg ? (ind_reg | IND_ERROR) : (ind_reg & ~IND_ERROR);
                    end
                end
                KIND_ALL_ON:
                begin
                    latch_next = 1'b1;
                    ind_next   = ind_reg | IND_MODE | IND_PULSE | IND_ERROR;
                end
                KIND_ALL_OFF:
                begin
                    latch_next = 1'b0;
                    ind_next   = ind_reg & ~IND_MODE;
                end
                default:
                begin
                    ind_next = ind_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_go && s1_is_tick)
        begin
            seg_valid_next = 1'b1;
        end
        else if (!seg_stall)
        begin
            seg_valid_next = 1'b0;
        end
        else
        begin
            seg_valid_next = seg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            seg_valid_reg <= 1'b0;
            digit_reg     <= DIGIT_RESET;
            ind_reg       <= 8'h00;
            scan_pos_reg  <= 3'd0;
            latch_reg     <= 1'b0;
            anim_reg      <= 3'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            seg_valid_reg <= seg_valid_next;
            digit_reg     <= digit_next;
            ind_reg       <= ind_next;
            scan_pos_reg  <= scan_pos_next;
            latch_reg     <= latch_next;
            anim_reg      <= anim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_kind_reg  <= kind;
            s1_value_reg <= value;
            s1_flag_reg  <= flag;
        end
        position_reg <= position_next;
        segments_reg <= segments_next;
    end

    a_position_tracks_scan: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> (position == scan_pos_reg) && (position <= POS_LAMPS))
        else $error("Output position does not match the scan position.");

    a_unused_segment_low: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> !segments[SEG_UNUSED_BIT])
        else $error("Unused segment bit is driven.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> s1_valid_reg && s1_is_tick && seg_valid && seg_stall)
        else $error("Input stalled without a blocked tick transaction.");

    a_latch_guards_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (latch_reg && s1_go && (s1_kind_reg == KIND_RUNNING))
        |=> ((ind_reg & IND_PULSE) == ($past(ind_reg) & IND_PULSE)))
        else $error("Running command changed the pulse lamp while the override latch is set.");

endmodule

@@ verif/tb_seven_segment_display_controller_unit.sv @@
// Self-checking testbench for the seven-segment display controller: directed, random and backpressure tests.
module tb_seven_segment_display_controller_unit
    import ssdc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        pos_t position;
        seg_t segments;
    } scan_result_t;

    localparam int GLYPH_COUNT = 21;
    localparam seg_t GLYPHS [GLYPH_COUNT] = '{
        8'hFC, 8'h18, 8'h6D, 8'h3D, 8'h99, 8'hB5, 8'hF5, 8'h1C, 8'hFD, 8'hBD,
        8'hDD, 8'hF1, 8'hE4, 8'h79, 8'hE5, 8'hC5, 8'h01, 8'hCD, 8'hF8, 8'h00,
        8'hFD
    };
    localparam logic [3:0] KIND_UNDEF_FIRST = 4'd12;
    localparam logic [3:0] KIND_UNDEF_LAST  = 4'd15;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SCANS_PER_FRAME = 5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [3:0]  kind = 4'd0;
    logic [15:0] value = 16'd0;
    logic        flag = 1'b0;
    logic        seg_valid;
    logic        seg_stall = 1'b0;
    logic [2:0]  position;
    logic [7:0]  segments;

    code_t        shown_digits [4];
    seg_t         lamp_bits;
    pos_t         scan_pos;
    logic         override_latch;
    logic [2:0]   dash_step;
    scan_result_t expected_scans [$];
    scan_result_t oldest_scan;

    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    seven_segment_display_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .kind      (kind),
        .value     (value),
        .flag      (flag),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .position  (position),
        .segments  (segments)
    );

    always #1 clk = ~clk;

    function automatic void format_number(input int unsigned n);
        int unsigned thousands;
        thousands = n / 1000;
        if (thousands > 31)
            thousands = 31;
        shown_digits[0] = code_t'(thousands);
        shown_digits[1] = code_t'((n / 100) % 10);
        shown_digits[2] = code_t'((n / 10) % 10);
        shown_digits[3] = code_t'(n % 10);
    endfunction

    function automatic void format_clock(input int unsigned minutes, input logic point);
        int unsigned hours;
        int unsigned mins;
        hours = (minutes / 60) % 60;
        mins = minutes % 60;
        lamp_bits &= ~IND_MODE;
        shown_digits[0] = code_t'(hours / 10);
        shown_digits[1] = code_t'(hours % 10);
        shown_digits[2] = code_t'(mins / 10);
        shown_digits[3] = code_t'(mins % 10);
        if (minutes != 0)
        begin
            if (point)
                lamp_bits |= IND_POINT;
            lamp_bits |= IND_TIME;
        end
        else
        begin
            // A zero time blanks the digits and walks a dash across them.
            lamp_bits = '0;
            for (int i = 0; i < 4; i++)
                shown_digits[i] = CODE_BLANK;
            shown_digits[dash_step[2:1]] = CODE_DASH;
            dash_step = dash_step + 3'd1;
        end
    endfunction

    function automatic void format_money(input int unsigned tenths, input logic unit);
        format_number(tenths / 10);
        lamp_bits &= ~IND_MODE;
        lamp_bits |= IND_MONEY;
        if (unit)
            lamp_bits |= IND_UNIT;
    endfunction

    function automatic void predict_display(input logic [3:0] k, input logic [15:0] v,
                                            input logic f);
        scan_result_t scan;
        code_t code;
        case (k)
            KIND_TICK:
            begin
                scan_pos = (scan_pos == POS_LAMPS) ? pos_t'(0) : scan_pos + pos_t'(1);
                scan.position = scan_pos;
                if (scan_pos == POS_LAMPS)
                    scan.segments = lamp_bits;
                else
                begin
                    code = shown_digits[scan_pos[1:0]];
                    scan.segments = (code < GLYPH_COUNT) ? GLYPHS[code] : '0;
                end
                scan.segments &= SEG_MASK;
                expected_scans.push_back(scan);
            end
            KIND_SHOW_TIME:
                format_clock(v, f);
            KIND_SET_TIME:
            begin
                format_clock(v, 1'b1);
                lamp_bits |= IND_SET;
            end
            KIND_SET_PULSE:
            begin
                format_number(v);
                lamp_bits &= ~IND_MODE;
                lamp_bits |= IND_SET | IND_PULSE;
            end
            KIND_SHOW_VALUE:
                format_number(v);
            KIND_MONEY:
                format_money(v, 1'b1);
            KIND_PAY_MONEY:
                format_money(v, 1'b0);
            KIND_SET_MONEY:
            begin
                format_money(v, 1'b1);
                lamp_bits |= IND_SET;
            end
            KIND_RUNNING:
                if ((lamp_bits & IND_SET) == '0 && !override_latch)
                    lamp_bits = f ? (lamp_bits | IND_PULSE) : (lamp_bits & ~IND_PULSE);
            KIND_ERROR:
                if (!override_latch)
                    lamp_bits = f ? (lamp_bits | IND_ERROR) : (lamp_bits & ~IND_ERROR);
            KIND_ALL_ON:
            begin
                override_latch = 1'b1;
                lamp_bits |= IND_MODE | IND_PULSE | IND_ERROR;
            end
            KIND_ALL_OFF:
            begin
                override_latch = 1'b0;
                lamp_bits &= ~IND_MODE;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_command(input logic [3:0] k, input logic [15:0] v = '0,
                                input logic f = 1'b0);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        kind <= k;
        value <= v;
        flag <= f;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_display(k, v, f);
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_command(KIND_TICK);
    endtask

    task automatic send_random_item();
        int pick;
        logic [3:0] k;
        logic [15:0] v;
        pick = $urandom_range(99);
        if (pick < 45)
            k = KIND_TICK;
        else if (pick < 48)
            k = 4'($urandom_range(KIND_UNDEF_LAST, KIND_UNDEF_FIRST));
        else
            k = 4'($urandom_range(KIND_ALL_OFF, KIND_SHOW_TIME));
        case ($urandom_range(9))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'($urandom_range(3599));
            3: v = 16'($urandom_range(32999, 31000));
            default: v = 16'($urandom);
        endcase
        send_command(k, v, 1'($urandom_range(1)));
    endtask

    task automatic wait_for_scans();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_scans.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_ticks(SCANS_PER_FRAME);
        send_command(KIND_SHOW_VALUE, 16'hFFFF);
        send_ticks(2);
        send_command(KIND_SHOW_TIME, 16'h0000, 1'b1);
        send_command(KIND_SET_TIME, 16'h0000);
        send_ticks(2);
        send_command(KIND_SET_PULSE, 16'd1234);
        send_command(KIND_RUNNING, 16'h0000, 1'b0);
        send_command(KIND_ALL_ON);
        send_command(KIND_ERROR, 16'h0000, 1'b0);
        send_command(KIND_RUNNING, 16'h0000, 1'b0);
        send_ticks(SCANS_PER_FRAME);
        send_command(KIND_ALL_OFF);
        send_command(KIND_ERROR, 16'h0000, 1'b1);
        for (int k = KIND_UNDEF_FIRST; k <= KIND_UNDEF_LAST; k++)
            send_command(4'(k), 16'hFFFF, 1'b1);
        send_command(KIND_SET_MONEY, 16'd9999);
        send_ticks(SCANS_PER_FRAME);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_random_item();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = LONG_HOLD_CYCLES;
        send_ticks(20);
        repeat (40)
            send_random_item();
        wait_for_scans();
        repeat (60)
            send_random_item();
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            seg_stall <= 1'b1;
            hold_left--;
        end
        else
            seg_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && seg_valid && !seg_stall)
        begin
            if (expected_scans.size() == 0)
            begin
                $error("unexpected segment transaction: position=%0d segments=%h",
                       position, segments);
                mismatch_count++;
            end
            else
            begin
                oldest_scan = expected_scans.pop_front();
                if (position !== oldest_scan.position)
                begin
                    $error("position: expected %0d, actual %0d", oldest_scan.position, position);
                    mismatch_count++;
                end
                if (segments !== oldest_scan.segments)
                begin
                    $error("segments: expected %h, actual %h", oldest_scan.segments, segments);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (seg_valid && !seg_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[seven_segment_display_controller_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 4; i++)
            shown_digits[i] = DIGIT_RESET[i];
        lamp_bits = '0;
        scan_pos = '0;
        override_latch = 1'b0;
        dash_step = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(300, 0, 0);
        test_random_traffic(300, 66, 0);
        test_random_traffic(300, 0, 66);
        test_random_traffic(300, 13, 13);
        test_output_backpressure();

        wait_for_scans();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[seven_segment_display_controller_unit] OK");
        else
            $display("[seven_segment_display_controller_unit] ERROR");
        $finish;
    end

endmodule
